// ----- src/tlbpt_pkg.sv -----
`default_nettype none

package tlbpt_pkg;

   // Fixed widths of the words on the ports.
   localparam int ADDR_W      = 16;
   localparam int FRAME_OUT_W = 8;
   localparam int COUNT_W     = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Default geometry.
   localparam int DEF_OFFSET_BITS = 8;
   localparam int DEF_PAGE_BITS   = 8;
   localparam int DEF_TLB_DEPTH   = 16;
   localparam int DEF_FRAME_COUNT = 256;

   // Saturating increment used by the shared counter unit.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/tlbpt_tlb.sv -----
`default_nettype none

module tlbpt_tlb #(
   parameter int PAGE_BITS  = 8,
   parameter int FRAME_BITS = 8,
   parameter int TLB_DEPTH  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [PAGE_BITS-1:0]  lookup_page,
   output logic                       lookup_hit,
   output logic [FRAME_BITS-1:0]      lookup_frame,
   input  wire logic                  fill_en,
   input  wire logic [PAGE_BITS-1:0]  fill_tag,
   input  wire logic [FRAME_BITS-1:0] fill_frame
);
   import tlbpt_pkg::*;

   localparam int PTR_W = $clog2(TLB_DEPTH);

   logic [PAGE_BITS-1:0]  tag_ff   [TLB_DEPTH];
   logic [FRAME_BITS-1:0] frame_ff [TLB_DEPTH];
   logic [TLB_DEPTH-1:0]  valid_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      ptr_in;
   logic [TLB_DEPTH-1:0]  match;

   // Fills only happen on a miss, so at most one entry can match and the
   // frames of the matching entries may simply be ORed together.
   always_comb begin
      lookup_frame = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == lookup_page);
         if (match[i]) begin
            lookup_frame = lookup_frame | frame_ff[i];
         end
      end
      lookup_hit = |match;
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (fill_en) begin
         ptr_in = (ptr_ff == PTR_W'(TLB_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (fill_en) begin
            valid_ff[ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         tag_ff[ptr_ff]   <= fill_tag;
         frame_ff[ptr_ff] <= fill_frame;
      end
   end

`ifndef SYNTHESIS
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one TLB entry matches the page");

   a_fill_on_miss: assert property (@(posedge clock) disable iff (reset)
      fill_en |-> !(valid_ff[ptr_ff] && match[ptr_ff] && (fill_tag == lookup_page)))
      else $error("TLB filled with a page that is already present");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(TLB_DEPTH - 1))
      else $error("FIFO pointer beyond the last TLB slot");
`endif

endmodule

`default_nettype wire

// ----- src/tlb_page_table_translate_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake             Words
// request   in         start, busy           req_logical_address
// response  out        rsp_valid (strobe)    rsp_physical_address .. rsp_faults_total
//
// An address is accepted at an edge where busy is low. It then passes the TLB state,
// for the parallel TLB compare, the page table read and the lookup count, and the
// page table state, for the fill and the hit or fault count; the response strobe
// is registered from the page table state. The next address can be taken at the
// edge that ends the strobe, so no new address is taken while one is in flight.
// After reset the page table mapped marks are cleared one entry per cycle, with busy
// held high. The response strobe lasts one cycle and cannot be stalled.

module tlb_page_table_translate_unit #(
   parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS,
   parameter int PAGE_BITS   = tlbpt_pkg::DEF_PAGE_BITS,
   parameter int TLB_DEPTH   = tlbpt_pkg::DEF_TLB_DEPTH,
   parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [tlbpt_pkg::ADDR_W-1:0]        req_logical_address,
   output logic                                     rsp_valid,
   output logic [tlbpt_pkg::ADDR_W-1:0]             rsp_physical_address,
   output logic [tlbpt_pkg::FRAME_OUT_W-1:0]        rsp_frame_number,
   output logic                                     rsp_tlb_hit,
   output logic                                     rsp_page_fault,
   output logic [tlbpt_pkg::COUNT_W-1:0]            rsp_lookups_total,
   output logic [tlbpt_pkg::COUNT_W-1:0]            rsp_hits_total,
   output logic [tlbpt_pkg::COUNT_W-1:0]            rsp_faults_total
);
   import tlbpt_pkg::*;

   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int PAGE_COUNT = 1 << PAGE_BITS;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_TLB   = 2'd2;
   localparam logic [1:0] S_PT    = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [PAGE_BITS-1:0]   clr_idx_ff, clr_idx_in;
   logic [ADDR_W-1:0]      addr_ff;
   logic [PAGE_BITS-1:0]   page;
   logic [OFFSET_BITS-1:0] offset;
   logic [ADDR_W+PAGE_BITS-1:0] addr_ext;

   logic                   tlb_hit_c;
   logic [FRAME_BITS-1:0]  tlb_frame_c;
   logic                   hit_ff;
   logic [FRAME_BITS-1:0]  hit_frame_ff;

   logic [FRAME_BITS:0]    pt_mem [PAGE_COUNT];
   logic [FRAME_BITS:0]    pt_rd_ff;
   logic                   pt_mapped;

   logic [FRAME_BITS-1:0]  next_free_ff, next_free_in;
   logic [COUNT_W-1:0]     lookup_ff, lookup_in;
   logic [COUNT_W-1:0]     hitcnt_ff, hitcnt_in;
   logic [COUNT_W-1:0]     faultcnt_ff, faultcnt_in;

   logic [COUNT_W-1:0]     inc_operand, inc_result;
   logic                   fault;
   logic                   fill_en;
   logic [FRAME_BITS-1:0]  frame;
   logic [FRAME_BITS+OFFSET_BITS+ADDR_W-1:0] phys_ext;
   logic [FRAME_BITS+FRAME_OUT_W-1:0]        frame_ext;

   assign busy     = (state_ff != S_IDLE);
   assign addr_ext = {{PAGE_BITS{1'b0}}, addr_ff};
   assign page     = addr_ext[OFFSET_BITS +: PAGE_BITS];
   assign offset   = addr_ff[OFFSET_BITS-1:0];

   tlbpt_tlb #(
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS),
      .TLB_DEPTH  (TLB_DEPTH)
   ) u_tlb (
      .clock        (clock),
      .reset        (reset),
      .lookup_page  (page),
      .lookup_hit   (tlb_hit_c),
      .lookup_frame (tlb_frame_c),
      .fill_en      (fill_en),
      .fill_tag     (page),
      .fill_frame   (frame)
   );

   // Resolution of the miss path in the page table stage.
   assign pt_mapped = pt_rd_ff[FRAME_BITS];
   assign fault     = (state_ff == S_PT) && !hit_ff && !pt_mapped;
   assign fill_en   = (state_ff == S_PT) && !hit_ff;

   always_comb begin
      if (hit_ff) begin
         frame = hit_frame_ff;
      end else if (pt_mapped) begin
         frame = pt_rd_ff[FRAME_BITS-1:0];
      end else begin
         frame = next_free_ff;
      end
   end

   // The one saturating incrementer serves the lookup count in the TLB stage
   // and the hit or fault count in the page table stage.
   always_comb begin
      if (state_ff == S_TLB) begin
         inc_operand = lookup_ff;
      end else if (hit_ff) begin
         inc_operand = hitcnt_ff;
      end else begin
         inc_operand = faultcnt_ff;
      end
      inc_result = sat_inc(inc_operand);
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      next_free_in = next_free_ff;
      lookup_in    = lookup_ff;
      hitcnt_in    = hitcnt_ff;
      faultcnt_in  = faultcnt_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + PAGE_BITS'(1);
            if (clr_idx_ff == {PAGE_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_TLB;
            end
         end
         S_TLB: begin
            lookup_in = inc_result;
            state_in  = S_PT;
         end
         S_PT: begin
            if (hit_ff) begin
               hitcnt_in = inc_result;
            end else if (!pt_mapped) begin
               faultcnt_in  = inc_result;
               next_free_in = (next_free_ff == FRAME_BITS'(FRAME_COUNT - 1)) ?
                              '0 : next_free_ff + FRAME_BITS'(1);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         next_free_ff <= '0;
         lookup_ff    <= '0;
         hitcnt_ff    <= '0;
         faultcnt_ff  <= '0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         next_free_ff <= next_free_in;
         lookup_ff    <= lookup_in;
         hitcnt_ff    <= hitcnt_in;
         faultcnt_ff  <= faultcnt_in;
         rsp_valid    <= (state_ff == S_PT);
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         addr_ff <= req_logical_address;
      end
      if (state_ff == S_TLB) begin
         hit_ff       <= tlb_hit_c;
         hit_frame_ff <= tlb_frame_c;
      end
   end

   // Page table: mapped mark and frame in one word.
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         pt_mem[clr_idx_ff] <= '0;
      end else if (fault) begin
         pt_mem[page] <= {1'b1, next_free_ff};
      end
      if (state_ff == S_TLB) begin
         pt_rd_ff <= pt_mem[page];
      end
   end

   assign phys_ext  = {{ADDR_W{1'b0}}, frame, offset};
   assign frame_ext = {{FRAME_OUT_W{1'b0}}, frame};

   always_ff @(posedge clock) begin
      if (state_ff == S_PT) begin
         rsp_physical_address <= phys_ext[ADDR_W-1:0];
         rsp_frame_number     <= frame_ext[FRAME_OUT_W-1:0];
         rsp_tlb_hit          <= hit_ff;
         rsp_page_fault       <= !hit_ff && !pt_mapped;
         rsp_lookups_total    <= lookup_ff;
         rsp_hits_total       <= hitcnt_in;
         rsp_faults_total     <= faultcnt_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_after_pt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_PT))
      else $error("response strobe without a page table stage");

   a_hit_xor_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("a word flagged both as TLB hit and as page fault");

   a_accept_to_tlb: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_TLB))
      else $error("accepted address did not enter the TLB stage");

   a_fault_advances: assert property (@(posedge clock) disable iff (reset)
      fault |=> (next_free_ff != $past(next_free_ff)))
      else $error("page fault did not advance the free frame pointer");
`endif

endmodule

`default_nettype wire

// ----- test/tlb_translation_checker.sv -----
`timescale 1ns / 1ps

module tlb_translation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_logical_address,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_physical_address,
   input  logic [7:0]  rsp_frame_number,
   input  logic        rsp_tlb_hit,
   input  logic        rsp_page_fault,
   input  logic [31:0] rsp_lookups_total,
   input  logic [31:0] rsp_hits_total,
   input  logic [31:0] rsp_faults_total,
   output int          errors,
   output int          pending
);

   localparam int OFF_W  = tlbpt_pkg::DEF_OFFSET_BITS;
   localparam int PG_W   = tlbpt_pkg::DEF_PAGE_BITS;
   localparam int DEPTH  = tlbpt_pkg::DEF_TLB_DEPTH;
   localparam int FRAMES = tlbpt_pkg::DEF_FRAME_COUNT;
   localparam int PAGES  = 1 << PG_W;

   typedef struct {
      logic [15:0] phys;
      logic [7:0]  frame;
      logic        hit;
      logic        fault;
      logic [31:0] lookups;
      logic [31:0] hits;
      logic [31:0] faults;
   } translation_type;

   translation_type translations[$];

   logic [PG_W-1:0] tlb_page[DEPTH];
   int              tlb_frame[DEPTH];
   bit [DEPTH-1:0]  tlb_live;
   int              page_frame[PAGES];
   bit [PAGES-1:0]  page_live;
   int              free_frame;
   int              victim;
   logic [31:0]     lookups;
   logic [31:0]     hits;
   logic [31:0]     faults;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic logic [31:0] bump(input logic [31:0] count);
      return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
   endfunction

   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input logic [31:0] seq);
      if (got !== want)
         report($sformatf("lookup %0d %s: got 0x%0h, expected 0x%0h", seq, name, got, want));
   endtask

   task automatic translate(input logic [15:0] addr);
      logic [PG_W-1:0]  pg;
      logic [OFF_W-1:0] off;
      int               frm;
      bit               hit;
      bit               flt;
      translation_type  t;
      pg  = addr[OFF_W +: PG_W];
      off = addr[OFF_W-1:0];
      frm = 0;
      hit = 0;
      flt = 0;
      lookups = bump(lookups);
      // Fills happen only on misses, so at most one entry can match; the lowest wins.
      for (int i = 0; i < DEPTH; i++) begin
         if (!hit && tlb_live[i] && tlb_page[i] == pg) begin
            frm = tlb_frame[i];
            hit = 1;
         end
      end
      if (hit) begin
         hits = bump(hits);
      end else begin
         if (page_live[pg]) begin
            frm = page_frame[pg];
         end else begin
            frm = free_frame % FRAMES;
            free_frame = (frm + 1) % FRAMES;
            page_frame[pg] = frm;
            page_live[pg] = 1;
            flt = 1;
            faults = bump(faults);
         end
         tlb_page[victim]  = pg;
         tlb_frame[victim] = frm;
         tlb_live[victim]  = 1;
         victim = (victim + 1) % DEPTH;
      end
      t.phys    = 16'((frm << OFF_W) + off);
      t.frame   = 8'(frm);
      t.hit     = hit;
      t.fault   = flt;
      t.lookups = lookups;
      t.hits    = hits;
      t.faults  = faults;
      translations.push_back(t);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tlb_live   = '0;
         page_live  = '0;
         free_frame = 0;
         victim     = 0;
         lookups    = '0;
         hits       = '0;
         faults     = '0;
         translations.delete();
      end else begin
         // A word accepted at this edge cannot have its result at the same edge.
         if (rsp_valid) begin
            if (translations.size() == 0) begin
               report($sformatf("result word with nothing outstanding, physical 0x%0h",
                                rsp_physical_address));
            end else begin
               translation_type t;
               t = translations.pop_front();
               check_field("physical_address", rsp_physical_address, t.phys, t.lookups);
               check_field("frame_number", rsp_frame_number, t.frame, t.lookups);
               check_field("tlb_hit", rsp_tlb_hit, t.hit, t.lookups);
               check_field("page_fault", rsp_page_fault, t.fault, t.lookups);
               check_field("lookups_total", rsp_lookups_total, t.lookups, t.lookups);
               check_field("hits_total", rsp_hits_total, t.hits, t.lookups);
               check_field("faults_total", rsp_faults_total, t.faults, t.lookups);
            end
         end
         if (start && !busy)
            translate(req_logical_address);
      end
      pending <= translations.size();
   end

endmodule

// ----- test/tlb_page_table_translate_unit_test.sv -----
`timescale 1ns / 1ps

module tlb_page_table_translate_unit_test;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 215;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_logical_address;
   logic        rsp_valid;
   logic [15:0] rsp_physical_address;
   logic [7:0]  rsp_frame_number;
   logic        rsp_tlb_hit;
   logic        rsp_page_fault;
   logic [31:0] rsp_lookups_total;
   logic [31:0] rsp_hits_total;
   logic [31:0] rsp_faults_total;
   int          error_count;
   int          pending_count;
   int          quiet_cycles;

   logic [7:0]  recent_pages[32];
   int          recent_head;
   int          recent_fill;

   tlb_page_table_translate_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_logical_address(req_logical_address),
      .rsp_valid(rsp_valid),
      .rsp_physical_address(rsp_physical_address),
      .rsp_frame_number(rsp_frame_number),
      .rsp_tlb_hit(rsp_tlb_hit),
      .rsp_page_fault(rsp_page_fault),
      .rsp_lookups_total(rsp_lookups_total),
      .rsp_hits_total(rsp_hits_total),
      .rsp_faults_total(rsp_faults_total)
   );

   tlb_translation_checker checker_i (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_logical_address(req_logical_address),
      .rsp_valid(rsp_valid),
      .rsp_physical_address(rsp_physical_address),
      .rsp_frame_number(rsp_frame_number),
      .rsp_tlb_hit(rsp_tlb_hit),
      .rsp_page_fault(rsp_page_fault),
      .rsp_lookups_total(rsp_lookups_total),
      .rsp_hits_total(rsp_hits_total),
      .rsp_faults_total(rsp_faults_total),
      .errors(error_count),
      .pending(pending_count)
   );

   initial begin
      clock = 0;
      reset = 1;
      start = 0;
      req_logical_address = '0;
   end

   always #6 clock = ~clock;

   // The run is ended if neither an address nor a result word moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send(input logic [15:0] addr);
      start <= 1;
      req_logical_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      recent_pages[recent_head] = addr[15:8];
      recent_head = (recent_head + 1) % 32;
      if (recent_fill < 32) recent_fill++;
   endtask

   task automatic idle_after(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [15:0] directed[$];
      int          pct[3];
      int          roll;
      int          back;
      int          base;
      int          stride;
      logic [7:0]  pg;

      quiet_cycles = 0;
      recent_head  = 0;
      recent_fill  = 0;
      pct = '{0, 82, 35};

      repeat (12) @(posedge clock);
      reset <= 0;

      // Extremes first, then sixteen fresh pages so the FIFO wraps and evicts
      // pages 0x00 and 0xFF, which must then come back from the page table.
      directed = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
      for (int p = 1; p <= 16; p++)
         directed.push_back({8'(p), 8'(p * 13)});
      directed.push_back(16'h0034);
      directed.push_back(16'hFF80);
      directed.push_back(16'h0101);
      foreach (directed[i]) send(directed[i]);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (recent_fill == 0 || roll >= 75) begin
               pg = 8'($urandom_range(255));
            end else begin
               // Recent pages mostly hit in the TLB; older ones mostly miss it
               // but are already mapped.
               if (roll < 40) back = $urandom_range(7);
               else back = $urandom_range(31, 8);
               if (back >= recent_fill) back = recent_fill - 1;
               pg = recent_pages[(recent_head + 31 - back) % 32];
            end
            send({pg, 8'($urandom_range(255))});
            idle_after(pct[phase]);
         end
         drain();
      end

      // Every page once in a scrambled order, so each page not yet mapped faults and the
      // free-frame counter comes round to zero.
      base   = $urandom_range(255);
      stride = 2 * $urandom_range(127) + 1;
      for (int k = 0; k < 256; k++)
         send({8'((base + k * stride) % 256), 8'($urandom_range(255))});
      drain();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
